[rtl/plre_pkg.sv]
// plre_pkg: shared types and constants of the posting list rice encoder
// no dependencies; used by plre_packer and posting_list_rice_encoder_unit
`timescale 1ns / 1ps
`default_nettype none

package plre_pkg;

  localparam int CODE_W  = 8;   // bits in one packed byte
  localparam int REM_W   = 31;  // widest remainder field
  localparam int RB_W    = 5;   // width of the rice_bits register
  localparam int DOC_W   = 32;  // width of the incoming document number
  localparam int COUNT_W = 8;
  localparam int TOTAL_W = 32;

  typedef struct packed {
    logic [DOC_W-1:0]   doc_number;
    logic [COUNT_W-1:0] occurrence_count;
    logic               list_end;
  } posting_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code_byte;
    logic               run_last;
    logic               list_done;
    logic [TOTAL_W-1:0] list_byte_total;
    logic               gap_error;
  } code_t;

  typedef struct packed {
    logic push;
    logic bit_value;
    logic mark_last;
    logic mark_done;
    logic pad;
    logic error;
    logic error_end;
  } pack_ctl_t;

endpackage

`default_nettype wire

[rtl/plre_packer.sv]
// plre_packer: packs code bits msb first into bytes, keeps the byte total and
// holds the output word register; depends on plre_pkg
`timescale 1ns / 1ps
`default_nettype none

module plre_packer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire plre_pkg::pack_ctl_t ctl,
  output logic                    ready,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output plre_pkg::code_t         out_data
);

  logic [plre_pkg::CODE_W-1:0]  acc;
  logic [2:0]                   pending;
  logic [plre_pkg::TOTAL_W-1:0] bytes;

  logic [plre_pkg::CODE_W-1:0]  acc_shift;
  logic [plre_pkg::CODE_W-1:0]  pad_byte;
  logic [plre_pkg::TOTAL_W-1:0] bytes_inc;
  logic                         emit;

  assign ready     = !out_valid || !out_stall;
  assign acc_shift = {acc[plre_pkg::CODE_W-2:0], ctl.bit_value};
  assign pad_byte  = acc << (4'(plre_pkg::CODE_W) - {1'b0, pending});
  assign bytes_inc = bytes + plre_pkg::TOTAL_W'(1);
  assign emit      = (ctl.push && pending == 3'(plre_pkg::CODE_W - 1))
                   || (ctl.pad && pending != 3'd0) || ctl.error;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pending   <= '0;
      bytes     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctl.push) begin
        if (pending == 3'(plre_pkg::CODE_W - 1)) begin
          out_data.code_byte       <= acc_shift;
          out_data.run_last        <= ctl.mark_last;
          out_data.list_done       <= ctl.mark_done;
          out_data.list_byte_total <= bytes_inc;
          out_data.gap_error       <= 1'b0;
          acc                      <= '0;
          pending                  <= '0;
          bytes                    <= bytes_inc;
        end else begin
          acc     <= acc_shift;
          pending <= pending + 3'd1;
        end
      end else if (ctl.pad) begin
        if (pending != 3'd0) begin
          out_data.code_byte       <= pad_byte;
          out_data.run_last        <= 1'b1;
          out_data.list_done       <= 1'b1;
          out_data.list_byte_total <= bytes_inc;
          out_data.gap_error       <= 1'b0;
        end
        acc     <= '0;
        pending <= '0;
        bytes   <= '0;
      end else if (ctl.error) begin
        out_data.code_byte       <= '0;
        out_data.run_last        <= 1'b1;
        out_data.list_done       <= ctl.error_end;
        out_data.list_byte_total <= bytes;
        out_data.gap_error       <= 1'b1;
        if (ctl.error_end) begin
          acc     <= '0;
          pending <= '0;
          bytes   <= '0;
        end
      end
    end
  end

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.push, ctl.pad, ctl.error}))
    else $error("packer given more than one operation");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.push || ctl.pad || ctl.error) |-> ready)
    else $error("packer operation while output word is held");

  a_pad_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.pad |=> (pending == 3'd0 && bytes == '0))
    else $error("list state not cleared after pad");

endmodule

`default_nettype wire

[rtl/posting_list_rice_encoder_unit.sv]
// posting_list_rice_encoder_unit: rice coding of document gaps, one code bit a cycle while the output is not held
// depends on plre_pkg and plre_packer
//
//   channel  | signals                      | word
//   input    | in_valid, in_stall, in_data  | plre_pkg::posting_t
//   output   | out_valid, out_stall, out_data | plre_pkg::code_t
//   config   | cfg_write, cfg_data          | rice_bits, 5 bits
//
// one posting at a time: setup (gap registered on accept, then S_ALIGN), then one code bit
// a cycle while the output is not held (quotient + 1 + rice_bits + occurrence_count bits),
// plus a pad step on a list end; a bad gap takes the setup steps and then the error word
// the bit-serial sequencer and its single output word register set the rate
// rst is synchronous and clears the list state and rice_bits
// a held output word stops the sequencer until it is taken
`timescale 1ns / 1ps
`default_nettype none

module posting_list_rice_encoder_unit #(
  parameter int DOC_BITS     = 32,
  parameter int MAX_QUOTIENT = 200
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire plre_pkg::posting_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output plre_pkg::code_t                 out_data,
  input  wire logic                       cfg_write,
  input  wire logic [plre_pkg::RB_W-1:0]  cfg_data
);

  localparam int GAP_W = DOC_BITS + 1;
  localparam int Q_W   = $clog2(MAX_QUOTIENT + 1);
  localparam int TOT_W = $clog2(MAX_QUOTIENT + 1 + plre_pkg::REM_W
                                + (1 << plre_pkg::COUNT_W));

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ALIGN  = 7'b0000010,
    S_UNARY  = 7'b0000100,
    S_REMAIN = 7'b0001000,
    S_COUNT  = 7'b0010000,
    S_PAD    = 7'b0100000,
    S_ERROR  = 7'b1000000
  } state_t;

  state_t                         state;
  logic [plre_pkg::RB_W-1:0]      rice_bits;
  logic [GAP_W-1:0]               prev;
  logic [GAP_W-1:0]               doc_plus_one;
  logic [GAP_W-1:0]               gap;
  logic                           gap_positive;
  logic [plre_pkg::COUNT_W-1:0]   count;
  logic                           list_end;
  logic [Q_W-1:0]                 q_cnt;
  logic [plre_pkg::RB_W-1:0]      rem_cnt;
  logic [plre_pkg::REM_W-1:0]     rem_sr;
  logic [plre_pkg::COUNT_W-1:0]   cnt_cnt;
  logic [TOT_W-1:0]               left;

  logic [DOC_BITS+plre_pkg::DOC_W-1:0] doc_wide;
  logic [GAP_W-1:0]               dp1_in;
  logic [GAP_W-1:0]               quot;
  logic [GAP_W+plre_pkg::REM_W-1:0] gap_wide;
  logic [plre_pkg::REM_W-1:0]     rem_low;
  logic                           bad_gap;
  logic [TOT_W-1:0]               after;
  logic                           accept;
  logic                           ready;
  state_t                         finish_state;
  plre_pkg::pack_ctl_t            ctl;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // document number trimmed to DOC_BITS and offset by one
  assign doc_wide = {{DOC_BITS{1'b0}}, in_data.doc_number};
  assign dp1_in   = {1'b0, doc_wide[DOC_BITS-1:0]} + GAP_W'(1);

  assign quot     = gap >> rice_bits;
  assign gap_wide = {{plre_pkg::REM_W{1'b0}}, gap};
  assign rem_low  = gap_wide[plre_pkg::REM_W-1:0];
  assign bad_gap  = !gap_positive || (quot > GAP_W'(MAX_QUOTIENT));

  assign after        = left - TOT_W'(1);
  assign finish_state = list_end ? S_PAD : S_IDLE;

  always_comb begin
    ctl           = '0;
    ctl.mark_last = (after == '0) || (!list_end && after < TOT_W'(plre_pkg::CODE_W));
    ctl.mark_done = list_end && (after == '0);
    ctl.error_end = list_end;
    unique case (state)
      S_UNARY: begin
        ctl.push      = ready;
        ctl.bit_value = (q_cnt != '0);
      end
      S_REMAIN: begin
        ctl.push      = ready;
        ctl.bit_value = rem_sr[plre_pkg::REM_W-1];
      end
      S_COUNT: begin
        ctl.push      = ready;
        ctl.bit_value = (cnt_cnt != plre_pkg::COUNT_W'(1));
      end
      S_PAD:   ctl.pad   = ready;
      S_ERROR: ctl.error = ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev      <= '0;
      rice_bits <= '0;
    end else begin
      if (cfg_write) begin
        rice_bits <= cfg_data;
      end
      if (ctl.push) begin
        left <= after;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            doc_plus_one <= dp1_in;
            gap          <= dp1_in - prev;
            gap_positive <= dp1_in > prev;
            count        <= in_data.occurrence_count;
            list_end     <= in_data.list_end;
            state        <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          q_cnt   <= quot[Q_W-1:0];
          rem_cnt <= rice_bits;
          rem_sr  <= rem_low << (5'(plre_pkg::REM_W) - rice_bits);
          cnt_cnt <= count;
          left    <= TOT_W'(quot[Q_W-1:0]) + TOT_W'(1) + TOT_W'(rice_bits)
                     + TOT_W'(count);
          if (bad_gap) begin
            state <= S_ERROR;
          end else begin
            prev  <= doc_plus_one;
            state <= S_UNARY;
          end
        end
        S_UNARY: begin
          if (ready) begin
            if (q_cnt != '0) begin
              q_cnt <= q_cnt - Q_W'(1);
            end else if (rice_bits != '0) begin
              state <= S_REMAIN;
            end else if (count != '0) begin
              state <= S_COUNT;
            end else begin
              state <= finish_state;
            end
          end
        end
        S_REMAIN: begin
          if (ready) begin
            rem_sr  <= rem_sr << 1;
            rem_cnt <= rem_cnt - 5'd1;
            if (rem_cnt == 5'd1) begin
              state <= (count != '0) ? S_COUNT : finish_state;
            end
          end
        end
        S_COUNT: begin
          if (ready) begin
            cnt_cnt <= cnt_cnt - plre_pkg::COUNT_W'(1);
            if (cnt_cnt == plre_pkg::COUNT_W'(1)) begin
              state <= finish_state;
            end
          end
        end
        S_PAD: begin
          if (ready) begin
            prev  <= '0;
            state <= S_IDLE;
          end
        end
        S_ERROR: begin
          if (ready) begin
            if (list_end) begin
              prev <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  plre_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_align_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALIGN) |-> $past(in_valid && !in_stall))
    else $error("setup entered without an accepted word");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.gap_error) |-> (out_data.run_last && out_data.code_byte == '0))
    else $error("error word malformed");

  a_remain_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_REMAIN) |-> (rem_cnt != '0))
    else $error("remainder phase with no bits left");

endmodule

`default_nettype wire
